// ----- src/multi_pattern_glob_matcher_unit_defines.svh -----
// Assertion macros used by the matcher top module.
`ifndef MULTI_PATTERN_GLOB_MATCHER_UNIT_DEFINES_SVH
`define MULTI_PATTERN_GLOB_MATCHER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define MPGM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("matcher check failed");
// antecedent implies consequent in the next cycle
`define MPGM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("matcher check failed");
`else
`define MPGM_ASSERT_NOW(label, ante, cons)
`define MPGM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- src/mpgm_pkg.sv -----
package mpgm_pkg;

   localparam int FUNC_W  = 2;
   localparam int INDEX_W = 4;
   localparam int POS_W   = 5;
   localparam int CHAR_W  = 8;
   localparam int MASK_W  = 16;
   localparam int CFG_W   = 5;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

   localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CHAR = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_EOS  = 2'd2;

   localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
   localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_QMARK  = 8'h3F;
   localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
   localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [CHAR_W-1:0] CH_BANG   = 8'h21;
   localparam logic [CHAR_W-1:0] CH_DASH   = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;

   // outcome of one token evaluation
   typedef struct packed {
      logic done;
      logic err;
      logic star;
      logic take;
   } tok_result_type;

endpackage

// ----- src/mpgm_pattern_ram.sv -----
module mpgm_pattern_ram import mpgm_pkg::*; #(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [CHAR_W-1:0] wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [CHAR_W-1:0] rd_data
);

   logic [CHAR_W-1:0] mem [DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/mpgm_token_eval.sv -----
module mpgm_token_eval import mpgm_pkg::*; #(
   parameter int LW = 6,
   parameter int IW = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [LW-1:0]     pos_in,
   input  logic [CHAR_W-1:0] char_in,
   input  logic [LW-1:0]     len_in,
   input  logic [CHAR_W-1:0] rd_data,
   output logic [IW-1:0]     fetch_index,
   output tok_result_type    result,
   output logic [IW-1:0]     target
);

   localparam logic [2:0] E_IDLE  = 3'd0;
   localparam logic [2:0] E_TOK   = 3'd1;
   localparam logic [2:0] E_ESC   = 3'd2;
   localparam logic [2:0] E_FIRST = 3'd3;
   localparam logic [2:0] E_TOP   = 3'd4;
   localparam logic [2:0] E_B1    = 3'd5;
   localparam logic [2:0] E_B2    = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic              phase_ff, phase_in;
   logic [IW-1:0]     ix_ff, ix_in;
   logic [CHAR_W-1:0] b0_ff, b0_in;
   logic              hit_ff, hit_in;
   logic              neg_ff, neg_in;
   logic              first_ff, first_in;
   logic [CHAR_W-1:0] bv;
   logic              hit_new;

   // bytes past the pattern end read as zero
   assign bv = (IW'(len_in) > ix_ff) ? rd_data : CH_NUL;
   assign fetch_index = ix_ff;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      ix_in    = ix_ff;
      b0_in    = b0_ff;
      hit_in   = hit_ff;
      neg_in   = neg_ff;
      first_in = first_ff;
      result   = '0;
      target   = ix_ff + IW'(1);
      hit_new  = hit_ff | (char_in == b0_ff);
      if (state_ff != E_IDLE && !phase_ff) begin
         // wait for the read data of ix
         phase_in = 1'b1;
      end else begin
         phase_in = 1'b0;
         unique case (state_ff)
            E_IDLE: begin
               if (start) begin
                  ix_in    = IW'(pos_in);
                  hit_in   = 1'b0;
                  neg_in   = 1'b0;
                  first_in = 1'b0;
                  state_in = E_TOK;
               end
            end
            E_TOK: begin
               state_in = E_IDLE;
               result.done = 1'b1;
               unique case (bv)
                  CH_NUL: ;
                  CH_STAR: result.star = 1'b1;
                  CH_QMARK: result.take = 1'b1;
                  CH_BSLASH: begin
                     result.done = 1'b0;
                     ix_in = ix_ff + IW'(1);
                     state_in = E_ESC;
                  end
                  CH_LBRACK: begin
                     result.done = 1'b0;
                     ix_in = ix_ff + IW'(1);
                     state_in = E_FIRST;
                  end
                  default: result.take = (bv == char_in);
               endcase
            end
            E_ESC: begin
               state_in = E_IDLE;
               result.done = 1'b1;
               result.err  = (bv == CH_NUL);
               result.take = (bv == char_in);
            end
            E_FIRST: begin
               if (bv == CH_NUL) begin
                  result.done = 1'b1;
                  result.err  = 1'b1;
                  state_in = E_IDLE;
               end else begin
                  neg_in   = (bv == CH_BANG);
                  ix_in    = (bv == CH_BANG) ? ix_ff + IW'(1) : ix_ff;
                  first_in = 1'b1;
                  state_in = E_TOP;
               end
            end
            E_TOP: begin
               if (bv == CH_NUL) begin
                  result.done = 1'b1;
                  result.err  = 1'b1;
                  state_in = E_IDLE;
               end else if (!first_ff && bv == CH_RBRACK) begin
                  result.done = 1'b1;
                  result.take = (hit_ff != neg_ff);
                  state_in = E_IDLE;
               end else begin
                  b0_in    = bv;
                  ix_in    = ix_ff + IW'(1);
                  first_in = 1'b0;
                  state_in = E_B1;
               end
            end
            E_B1: begin
               if (bv == CH_DASH) begin
                  ix_in    = ix_ff + IW'(1);
                  state_in = E_B2;
               end else begin
                  // single member, then test for the class end
                  hit_in = hit_new;
                  if (bv == CH_NUL) begin
                     result.done = 1'b1;
                     result.err  = 1'b1;
                     state_in = E_IDLE;
                  end else if (bv == CH_RBRACK) begin
                     result.done = 1'b1;
                     result.take = (hit_new != neg_ff);
                     state_in = E_IDLE;
                  end else begin
                     b0_in = bv;
                     ix_in = ix_ff + IW'(1);
                  end
               end
            end
            E_B2: begin
               if (bv != CH_RBRACK) begin
                  hit_in   = hit_ff | ((b0_ff <= char_in) && (char_in <= bv));
                  ix_in    = ix_ff + IW'(1);
                  state_in = E_TOP;
               end else begin
                  // dash before the closing bracket is a plain member
                  hit_in   = hit_new;
                  b0_in    = CH_DASH;
                  state_in = E_B1;
               end
            end
            default: state_in = E_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
      ix_ff    <= ix_in;
      b0_ff    <= b0_in;
      hit_ff   <= hit_in;
      neg_ff   <= neg_in;
      first_ff <= first_in;
   end

endmodule

// ----- src/multi_pattern_glob_matcher_unit.sv -----
// Channel   Direction  Handshake                Payload
// req_      in         req_tvalid/req_tready    tuser func, tdata index/position/char
// rsp_      out        rsp_tvalid/rsp_tready    tdata mask/any/error
// csr_      in         csr_valid/csr_ready      csr_data patterns_in_use
// After reset the pattern memory is cleared, with req_tready low.
// A load rescans the row through the one read port to recompute its length and
// final position.
// A character walks every live position of every pattern in use; each pattern byte
// is fetched through the shared read port.
// End of string checks each pattern in use in turn; a stalled result holds until taken.
module multi_pattern_glob_matcher_unit import mpgm_pkg::*; #(
   parameter int PATTERNS      = 16,
   parameter int PATTERN_BYTES = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [3:0] pattern_index, [8:4] position, [16:9] char_value, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] func
   input  logic [FUNC_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [15:0] match_mask, [16] any_match, [17] syntax_error, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CFG_W-1:0]      csr_data
);

`include "multi_pattern_glob_matcher_unit_defines.svh"

   localparam int DEPTH = PATTERNS * PATTERN_BYTES;
   localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW  = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
   localparam int PCW = $clog2(PATTERNS + 1);
   localparam int LW  = $clog2(PATTERN_BYTES + 1);
   localparam int IW  = LW + 1;
   localparam int SW  = PATTERN_BYTES + 1;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_LSWEEP = 3'd2;
   localparam logic [2:0] S_PSTART = 3'd3;
   localparam logic [2:0] S_POS    = 3'd4;
   localparam logic [2:0] S_WAIT   = 3'd5;
   localparam logic [2:0] S_EOS    = 3'd6;
   localparam logic [2:0] S_OUT    = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [CFG_W-1:0]    cfg_ff;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [PCW-1:0]      pat_ff, pat_in;
   logic [INDEX_W-1:0]  ld_idx_ff, ld_idx_in;
   logic [LW-1:0]       k_ff, k_in;
   logic [LW-1:0]       fin_acc_ff, fin_acc_in;
   logic                lphase_ff, lphase_in;
   logic [CHAR_W-1:0]   char_ff, char_in;
   logic [LW-1:0]       p_ff, p_in;
   logic [SW-1:0]       cur_ff, cur_in;
   logic [SW-1:0]       nxt_ff, nxt_in;
   logic [SW-1:0]       active_ff [PATTERNS];
   logic [LW-1:0]       len_ff [PATTERNS];
   logic [LW-1:0]       fin_ff [PATTERNS];
   logic                err_ff, err_in;
   logic [MASK_W-1:0]   mask_ff, mask_in;
   logic                any_ff, any_in;
   logic                rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic                req_xfer;
   logic [FUNC_W-1:0]   req_func;
   logic [INDEX_W-1:0]  req_index;
   logic [POS_W-1:0]    req_pos;
   logic [CHAR_W-1:0]   req_char;
   logic [PCW-1:0]      n_use;
   logic [PW-1:0]       pat_sel;
   logic [PW-1:0]       ld_sel;
   logic                load_ok;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [CHAR_W-1:0]   wr_data;
   logic [AW-1:0]       rd_addr;
   logic [CHAR_W-1:0]   rd_data;
   logic                ev_start;
   logic [IW-1:0]       ev_index;
   tok_result_type      ev_result;
   logic [IW-1:0]       ev_target;
   logic                len_wr, set_rearm, act_wr;
   logic [LW-1:0]       len_val, fin_val;
   logic                pat_hit;
   logic                out_free;

   assign req_func  = req_tuser;
   assign req_index = req_tdata[3:0];
   assign req_pos   = req_tdata[8:4];
   assign req_char  = req_tdata[16:9];
   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer  = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign n_use   = (32'(cfg_ff) > PATTERNS) ? PCW'(PATTERNS) : PCW'(cfg_ff);
   assign pat_sel = pat_ff[PW-1:0];
   assign ld_sel  = PW'(ld_idx_ff);
   assign load_ok = (32'(req_index) < PATTERNS) && (32'(req_pos) < PATTERN_BYTES);

   // memory ports: clearing sweep or pattern load on write, scan or token on read
   always_comb begin
      if (state_ff == S_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = CH_NUL;
      end else begin
         wr_en   = req_xfer && (req_func == FUNC_LOAD) && load_ok;
         wr_addr = AW'(32'(req_index) * PATTERN_BYTES + 32'(req_pos));
         wr_data = req_char;
      end
      if (state_ff == S_LSWEEP) begin
         rd_addr = AW'(32'(ld_idx_ff) * PATTERN_BYTES + 32'(k_ff));
      end else begin
         rd_addr = AW'(32'(pat_ff) * PATTERN_BYTES + 32'(ev_index[LW-1:0]));
      end
   end

   mpgm_pattern_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mpgm_token_eval #(
      .LW (LW),
      .IW (IW)
   ) u_eval (
      .clock       (clock),
      .reset       (reset),
      .start       (ev_start),
      .pos_in      (p_ff),
      .char_in     (char_ff),
      .len_in      (len_ff[pat_sel]),
      .rd_data     (rd_data),
      .fetch_index (ev_index),
      .result      (ev_result),
      .target      (ev_target)
   );

   // any live position at or past the final position
   always_comb begin
      pat_hit = 1'b0;
      for (int b = 0; b < SW; b++) begin
         if (32'(b) >= 32'(fin_ff[pat_sel]) && active_ff[pat_sel][b]) begin
            pat_hit = 1'b1;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      pat_in     = pat_ff;
      ld_idx_in  = ld_idx_ff;
      k_in       = k_ff;
      fin_acc_in = fin_acc_ff;
      lphase_in  = lphase_ff;
      char_in    = char_ff;
      p_in       = p_ff;
      cur_in     = cur_ff;
      nxt_in     = nxt_ff;
      err_in     = err_ff;
      mask_in    = mask_ff;
      any_in     = any_ff;
      ev_start   = 1'b0;
      len_wr     = 1'b0;
      len_val    = k_ff;
      fin_val    = fin_acc_ff;
      act_wr     = 1'b0;
      set_rearm  = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (32'(clr_ff) == DEPTH - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               char_in   = req_char;
               ld_idx_in = req_index;
               pat_in    = '0;
               mask_in   = '0;
               any_in    = 1'b0;
               k_in      = '0;
               fin_acc_in = '0;
               lphase_in = 1'b0;
               unique case (req_func)
                  FUNC_LOAD: if (load_ok) state_in = S_LSWEEP;
                  FUNC_CHAR: if (!err_ff && n_use != '0) state_in = S_PSTART;
                  FUNC_EOS: state_in = err_ff ? S_OUT : S_EOS;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_LSWEEP: begin
            lphase_in = !lphase_ff;
            if (lphase_ff) begin
               if (rd_data == CH_NUL) begin
                  len_wr   = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  fin_acc_in = (rd_data != CH_STAR) ? k_ff + LW'(1) : fin_acc_ff;
                  if (32'(k_ff) == PATTERN_BYTES - 1) begin
                     len_wr   = 1'b1;
                     len_val  = LW'(PATTERN_BYTES);
                     fin_val  = fin_acc_in;
                     state_in = S_IDLE;
                  end else begin
                     k_in = k_ff + LW'(1);
                  end
               end
            end
         end
         S_PSTART: begin
            cur_in   = active_ff[pat_sel];
            nxt_in   = '0;
            p_in     = '0;
            state_in = S_POS;
         end
         S_POS: begin
            if (p_ff > len_ff[pat_sel]) begin
               // commit this pattern, move to the next
               act_wr = 1'b1;
               pat_in = pat_ff + PCW'(1);
               state_in = (pat_ff + PCW'(1) == n_use) ? S_IDLE : S_PSTART;
            end else if (!cur_ff[p_ff]) begin
               p_in = p_ff + LW'(1);
            end else begin
               ev_start = 1'b1;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (ev_result.done) begin
               if (ev_result.err) begin
                  err_in   = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  if (ev_result.star) begin
                     cur_in[LW'(p_ff + LW'(1))] = 1'b1;
                     nxt_in[p_ff] = 1'b1;
                  end
                  if (ev_result.take && IW'(len_ff[pat_sel]) >= ev_target) begin
                     nxt_in[ev_target[LW-1:0]] = 1'b1;
                  end
                  p_in     = p_ff + LW'(1);
                  state_in = S_POS;
               end
            end
         end
         S_EOS: begin
            if (pat_ff == n_use) begin
               state_in = S_OUT;
            end else begin
               if (pat_hit) begin
                  any_in = 1'b1;
                  for (int j = 0; j < MASK_W; j++) begin
                     if (32'(pat_ff) == j) begin
                        mask_in[j] = 1'b1;
                     end
                  end
               end
               pat_in = pat_ff + PCW'(1);
            end
         end
         S_OUT: begin
            if (out_free) begin
               set_rearm = 1'b1;
               err_in    = 1'b0;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         cfg_ff       <= CFG_RESET;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lphase_ff    <= 1'b0;
         for (int i = 0; i < PATTERNS; i++) begin
            active_ff[i] <= SW'(1);
            len_ff[i]    <= '0;
            fin_ff[i]    <= '0;
         end
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         err_ff    <= err_in;
         lphase_ff <= lphase_in;
         if (csr_valid && csr_ready) begin
            cfg_ff <= csr_data;
         end
         if (len_wr) begin
            len_ff[ld_sel] <= len_val;
            fin_ff[ld_sel] <= fin_val;
         end
         // re-arm every pattern after the result, else commit the one just walked
         if (set_rearm) begin
            for (int i = 0; i < PATTERNS; i++) begin
               active_ff[i] <= SW'(1);
            end
         end else if (act_wr) begin
            active_ff[pat_sel] <= nxt_ff;
         end
         // hold the result until the transfer completes
         if (set_rearm) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (set_rearm) begin
         rsp_data_ff <= RSP_DATA_W'({err_ff, any_ff & !err_ff,
                                     mask_ff & {MASK_W{!err_ff}}});
      end
      pat_ff     <= pat_in;
      ld_idx_ff  <= ld_idx_in;
      k_ff       <= k_in;
      fin_acc_ff <= fin_acc_in;
      char_ff    <= char_in;
      p_ff       <= p_in;
      cur_ff     <= cur_in;
      nxt_ff     <= nxt_in;
      mask_ff    <= mask_in;
      any_ff     <= any_in;
   end

   // a character after a syntax error is dropped at once
   `MPGM_ASSERT_NEXT(a_err_drops_char,
      req_xfer && req_func == FUNC_CHAR && err_ff, state_ff == S_IDLE)
   // a malformed token always latches the error flag
   `MPGM_ASSERT_NEXT(a_err_latched,
      state_ff == S_WAIT && ev_result.done && ev_result.err, err_ff)
   // no result while the pattern memory is being cleared
   `MPGM_ASSERT_NOW(a_clear_quiet, state_ff == S_CLEAR, !rsp_valid_ff && !req_tready)

endmodule
